/* rtl/weighted_plane_row_sad_macros.svh */
// ---------------------------------------------------------------------------
// weighted_plane_row_sad_macros.svh
// Assertion helpers shared by the row SAD block.
// ---------------------------------------------------------------------------
`ifndef WEIGHTED_PLANE_ROW_SAD_MACROS_SVH
`define WEIGHTED_PLANE_ROW_SAD_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define WPRS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define WPRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/wprs_pkg.sv */
// ---------------------------------------------------------------------------
// wprs_pkg
// Widths, limits, codes and shared types of the weighted row SAD block.
// ---------------------------------------------------------------------------
`default_nettype none

package wprs_pkg;

    // Chunk geometry
    localparam int LANES     = 16;
    localparam int BYTE_W    = 8;
    localparam int WORD_W    = 64;
    localparam int PLANES    = 3;

    // Field widths
    localparam int PLANE_W   = 2;
    localparam int COUNT_W   = 5;
    localparam int WEIGHT_W  = 8;
    localparam int CFG_IDX_W = 2;

    // Arithmetic widths: 16 x 255 fits in 12 bits, 18 x 8 bit products in 26
    localparam int SAD_W     = 12;
    localparam int SUM_W     = 18;
    localparam int PROD_W    = SUM_W + WEIGHT_W;
    localparam int COST_W    = 28;
    localparam int TOTAL_W   = 38;

    localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // Plane codes; the fourth code adds nothing
    localparam logic [PLANE_W-1:0] PLANE_LUMA = 2'd0;
    localparam logic [PLANE_W-1:0] PLANE_CB   = 2'd1;
    localparam logic [PLANE_W-1:0] PLANE_CR   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_LUMA = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_CB   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_CR   = 2'd2;

    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 8'd1;

    // Per-beat control that follows the pixel data down the pipe
    typedef struct packed {
        logic [PLANE_W-1:0] plane;
        logic               row_end;
        logic               frame_end;
    } t_ctrl;

    typedef logic [PLANES-1:0][SUM_W-1:0]    t_sums;
    typedef logic [PLANES-1:0][WEIGHT_W-1:0] t_weights;

endpackage

`default_nettype wire

/* rtl/wprs_chunk_if.sv */
// ---------------------------------------------------------------------------
// wprs_chunk_if
// Input channel: one 16-byte chunk of old and new pixels per beat.
// ---------------------------------------------------------------------------
`default_nettype none

interface wprs_chunk_if;
    import wprs_pkg::*;

    logic                valid;
    logic                ready;
    logic [WORD_W-1:0]   old_pixels_low;
    logic [WORD_W-1:0]   old_pixels_high;
    logic [WORD_W-1:0]   new_pixels_low;
    logic [WORD_W-1:0]   new_pixels_high;
    logic [PLANE_W-1:0]  plane;
    logic [COUNT_W-1:0]  valid_bytes;
    logic                row_end;
    logic                frame_end;

    modport source (
        output valid, old_pixels_low, old_pixels_high, new_pixels_low,
               new_pixels_high, plane, valid_bytes, row_end, frame_end,
        input  ready
    );

    modport sink (
        input  valid, old_pixels_low, old_pixels_high, new_pixels_low,
               new_pixels_high, plane, valid_bytes, row_end, frame_end,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/wprs_result_if.sv */
// ---------------------------------------------------------------------------
// wprs_result_if
// Output channel: one row cost and running frame total per beat.
// ---------------------------------------------------------------------------
`default_nettype none

interface wprs_result_if;
    import wprs_pkg::*;

    logic                valid;
    logic                ready;
    logic [COST_W-1:0]   row_cost;
    logic [TOTAL_W-1:0]  frame_cost;
    logic                last_row;

    modport source (
        output valid, row_cost, frame_cost, last_row,
        input  ready
    );

    modport sink (
        input  valid, row_cost, frame_cost, last_row,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/weighted_plane_row_sad.sv */
// ---------------------------------------------------------------------------
// weighted_plane_row_sad: weighted per-plane row sum of absolute differences
// A row-end chunk's result passes the lane, merge, sum snapshot, product, cost and output registers.
// Throughput: one chunk per cycle; the six-stage pipe stalls, and ready drops,
// only while a result waits in the output register with ready low downstream.
// Reset (i_rst_n, synchronous): pipe empty, sums and total zero, weights one.
// ---------------------------------------------------------------------------
`default_nettype none
`include "weighted_plane_row_sad_macros.svh"

module weighted_plane_row_sad (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    wprs_chunk_if.sink                       i_chunk,
    wprs_result_if.source                    o_result,
    input  logic                             i_cfg_we,
    input  logic [wprs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [wprs_pkg::WEIGHT_W-1:0]    i_cfg_data
);
    import wprs_pkg::*;

    // Stage valids and control
    logic                 r1_v, r2_v, r3_v, r4_v, r5_v, r_out_v;
    t_ctrl                r1_ctrl, r2_ctrl;
    logic                 r3_last, r4_last, r5_last;

    // Stage moves
    logic                 en1, en2, en3, en4, en5, en_out;
    logic                 take2;
    logic                 in_accept;

    // Datapath
    logic [2*WORD_W-1:0]             old_cat, new_cat;
    logic [LANES-1:0][BYTE_W-1:0]    diffs;
    logic [SAD_W-1:0]                sad;
    t_sums                           snap;
    logic [COST_W-1:0]               cost;
    t_weights                        r_weights;

    // Output stage and frame total
    logic [TOTAL_W:0]     total_wide;
    logic [TOTAL_W-1:0]   n_total_sat;
    logic [TOTAL_W-1:0]   r_total;
    logic [COST_W-1:0]    r_out_cost;
    logic [TOTAL_W-1:0]   r_out_frame;
    logic                 r_out_last;

    // Backpressure chain: a stage loads when empty or when it drains
    assign en_out    = !r_out_v || o_result.ready;
    assign en5       = !r5_v || en_out;
    assign en4       = !r4_v || en5;
    assign en3       = !r3_v || en4;
    assign take2     = r2_v && (!r2_ctrl.row_end || en3);
    assign en2       = !r2_v || take2;
    assign en1       = !r1_v || en2;
    assign in_accept = i_chunk.valid && en1;

    assign i_chunk.ready = en1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weights <= {PLANES{WEIGHT_RESET}};
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_WEIGHT_LUMA: r_weights[PLANE_LUMA] <= i_cfg_data;
                REG_WEIGHT_CB:   r_weights[PLANE_CB]   <= i_cfg_data;
                REG_WEIGHT_CR:   r_weights[PLANE_CR]   <= i_cfg_data;
                default:         r_weights             <= r_weights;
            endcase
        end
    end

    // Lanes
    assign old_cat = {i_chunk.old_pixels_high, i_chunk.old_pixels_low};
    assign new_cat = {i_chunk.new_pixels_high, i_chunk.new_pixels_low};

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        wprs_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (en1),
            .i_use  (COUNT_W'(g) < i_chunk.valid_bytes),
            .i_old  (old_cat[g*BYTE_W +: BYTE_W]),
            .i_new  (new_cat[g*BYTE_W +: BYTE_W]),
            .o_diff (diffs[g])
        );
    end

    // Merge of the lanes
    wprs_merge u_merge (
        .i_clk   (i_clk),
        .i_en    (en2),
        .i_diffs (diffs),
        .o_sad   (sad)
    );

    // Plane sums
    wprs_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take2),
        .i_ctrl  (r2_ctrl),
        .i_sad   (sad),
        .o_snap  (snap)
    );

    // Weighting
    wprs_weight u_weight (
        .i_clk     (i_clk),
        .i_prod_en (en4),
        .i_cost_en (en5),
        .i_snap    (snap),
        .i_weights (r_weights),
        .o_cost    (cost)
    );

    // Pipeline control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r3_v    <= 1'b0;
            r4_v    <= 1'b0;
            r5_v    <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (en1)    r1_v    <= in_accept;
            if (en2)    r2_v    <= r1_v;
            if (en3)    r3_v    <= take2 && r2_ctrl.row_end;
            if (en4)    r4_v    <= r3_v;
            if (en5)    r5_v    <= r4_v;
            if (en_out) r_out_v <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_ctrl.plane     <= i_chunk.plane;
            r1_ctrl.row_end   <= i_chunk.row_end;
            r1_ctrl.frame_end <= i_chunk.frame_end;
        end
        if (en2) r2_ctrl <= r1_ctrl;
        if (en3) r3_last <= r2_ctrl.frame_end;
        if (en4) r4_last <= r3_last;
        if (en5) r5_last <= r4_last;
    end

    // Saturating frame total
    assign total_wide  = {1'b0, r_total} + (TOTAL_W + 1)'(cost);
    assign n_total_sat = total_wide[TOTAL_W] ? TOTAL_MAX : total_wide[TOTAL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (en_out && r5_v) begin
            r_total <= r5_last ? '0 : n_total_sat;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (en_out && r5_v) begin
            r_out_cost  <= cost;
            r_out_frame <= n_total_sat;
            r_out_last  <= r5_last;
        end
    end

    assign o_result.valid      = r_out_v;
    assign o_result.row_cost   = r_out_cost;
    assign o_result.frame_cost = r_out_frame;
    assign o_result.last_row   = r_out_last;

    // Checks
    `WPRS_ASSERT_NOW(a_stall_only_from_output, i_clk, i_rst_n, !i_chunk.ready, r_out_v && !o_result.ready, "input stalled while output is free")
    `WPRS_ASSERT_NOW(a_total_covers_row, i_clk, i_rst_n, r_out_v, r_out_frame >= TOTAL_W'(r_out_cost), "frame total below row cost")
    `WPRS_ASSERT_NEXT(a_total_clears_at_frame_end, i_clk, i_rst_n, en_out && r5_v && r5_last, r_total == '0, "frame total not cleared after frame end")
endmodule

`default_nettype wire

/* rtl/wprs_lane.sv */
// ---------------------------------------------------------------------------
// wprs_lane
// One byte lane: registered absolute difference, zero when the lane is unused.
// ---------------------------------------------------------------------------
`default_nettype none

module wprs_lane (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic                         i_use,
    input  logic [wprs_pkg::BYTE_W-1:0]  i_old,
    input  logic [wprs_pkg::BYTE_W-1:0]  i_new,
    output logic [wprs_pkg::BYTE_W-1:0]  o_diff
);
    import wprs_pkg::*;

    logic [BYTE_W-1:0] n_diff;
    logic [BYTE_W-1:0] r_diff;

    // |old - new|, masked past the valid count
    always_comb begin
        if (!i_use) begin
            n_diff = '0;
        end else if (i_old > i_new) begin
            n_diff = i_old - i_new;
        end else begin
            n_diff = i_new - i_old;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_diff <= n_diff;
        end
    end

    assign o_diff = r_diff;
endmodule

`default_nettype wire

/* rtl/wprs_merge.sv */
// ---------------------------------------------------------------------------
// wprs_merge
// Adder tree over the sixteen lane differences, registered chunk SAD.
// ---------------------------------------------------------------------------
`default_nettype none

module wprs_merge (
    input  logic                                            i_clk,
    input  logic                                            i_en,
    input  logic [wprs_pkg::LANES-1:0][wprs_pkg::BYTE_W-1:0] i_diffs,
    output logic [wprs_pkg::SAD_W-1:0]                      o_sad
);
    import wprs_pkg::*;

    logic [8:0]       l1 [8];
    logic [9:0]       l2 [4];
    logic [10:0]      l3 [2];
    logic [SAD_W-1:0] n_sad;
    logic [SAD_W-1:0] r_sad;

    // Four levels of pairwise adds, each one bit wider
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            l1[k] = {1'b0, i_diffs[2*k]} + {1'b0, i_diffs[2*k+1]};
        end
        for (int k = 0; k < 4; k++) begin
            l2[k] = {1'b0, l1[2*k]} + {1'b0, l1[2*k+1]};
        end
        for (int k = 0; k < 2; k++) begin
            l3[k] = {1'b0, l2[2*k]} + {1'b0, l2[2*k+1]};
        end
        n_sad = {1'b0, l3[0]} + {1'b0, l3[1]};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sad <= n_sad;
        end
    end

    assign o_sad = r_sad;
endmodule

`default_nettype wire

/* rtl/wprs_accum.sv */
// ---------------------------------------------------------------------------
// wprs_accum
// Per-plane saturating row sums; snapshot and clear on a row-end beat.
// ---------------------------------------------------------------------------
`default_nettype none

module wprs_accum (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_take,
    input  wprs_pkg::t_ctrl             i_ctrl,
    input  logic [wprs_pkg::SAD_W-1:0]  i_sad,
    output wprs_pkg::t_sums             o_snap
);
    import wprs_pkg::*;

    t_sums             r_sums;
    t_sums             n_sums;
    t_sums             n_snap;
    t_sums             r_snap;
    logic [SUM_W:0]    wide [PLANES];

    // Add into the addressed plane, saturate, clear all on row end
    always_comb begin
        for (int p = 0; p < PLANES; p++) begin
            wide[p] = {1'b0, r_sums[p]} + (SUM_W + 1)'(i_sad);
            if (i_ctrl.plane == PLANE_W'(p)) begin
                n_snap[p] = wide[p][SUM_W] ? SUM_MAX : wide[p][SUM_W-1:0];
            end else begin
                n_snap[p] = r_sums[p];
            end
            n_sums[p] = i_ctrl.row_end ? '0 : n_snap[p];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sums <= '0;
        end else if (i_take) begin
            r_sums <= n_sums;
        end
    end

    // Row sums including the closing chunk
    always_ff @(posedge i_clk) begin
        if (i_take && i_ctrl.row_end) begin
            r_snap <= n_snap;
        end
    end

    assign o_snap = r_snap;
endmodule

`default_nettype wire

/* rtl/wprs_weight.sv */
// ---------------------------------------------------------------------------
// wprs_weight
// Weighting: three registered 18x8 products, then a registered row cost.
// ---------------------------------------------------------------------------
`default_nettype none

module wprs_weight (
    input  logic                         i_clk,
    input  logic                         i_prod_en,
    input  logic                         i_cost_en,
    input  wprs_pkg::t_sums              i_snap,
    input  wprs_pkg::t_weights           i_weights,
    output logic [wprs_pkg::COST_W-1:0]  o_cost
);
    import wprs_pkg::*;

    logic [PROD_W-1:0] n_prod [PLANES];
    logic [PROD_W-1:0] r_prod [PLANES];
    logic [COST_W-1:0] n_cost;
    logic [COST_W-1:0] r_cost;

    // One multiplier per plane
    always_comb begin
        for (int p = 0; p < PLANES; p++) begin
            n_prod[p] = {{WEIGHT_W{1'b0}}, i_snap[p]} * {{SUM_W{1'b0}}, i_weights[p]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_prod_en) begin
            for (int p = 0; p < PLANES; p++) begin
                r_prod[p] <= n_prod[p];
            end
        end
    end

    // Three-input add of the products
    assign n_cost = COST_W'(r_prod[0]) + COST_W'(r_prod[1]) + COST_W'(r_prod[2]);

    always_ff @(posedge i_clk) begin
        if (i_cost_en) begin
            r_cost <= n_cost;
        end
    end

    assign o_cost = r_cost;
endmodule

`default_nettype wire

/* dv/wprs_row_cost_checker.sv */
`timescale 1ns / 1ps

// ---------------------------------------------------------------------------
// wprs_row_cost_checker
// Follows chunk beats, weight writes and result beats of the row SAD block.
// It keeps its own plane sums, weights and frame total, predicts the row
// cost of every row-end chunk, and compares each result beat with the
// oldest prediction, field by field.
// ---------------------------------------------------------------------------

module wprs_row_cost_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    wprs_chunk_if                          i_chunk,
    wprs_result_if                         i_result,
    input  logic                           i_cfg_we,
    input  logic [wprs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [wprs_pkg::WEIGHT_W-1:0]  i_cfg_data,
    output int                             o_fail_count,
    output int                             o_rows_pending
);
    import wprs_pkg::*;

    typedef struct packed {
        logic [COST_W-1:0]  row_cost;
        logic [TOTAL_W-1:0] frame_cost;
        logic               last_row;
    } t_row_cost;

    t_row_cost           expected_rows[$];
    logic [SUM_W-1:0]    plane_sum[PLANES];
    logic [WEIGHT_W-1:0] weight[PLANES];
    logic [TOTAL_W-1:0]  frame_total;
    int                  fail_count   = 0;
    int                  rows_pending = 0;

    assign o_fail_count   = fail_count;
    assign o_rows_pending = rows_pending;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ns: %s mismatch: got %0d, expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    // Add one chunk into its plane sum; a row end closes the row
    task automatic fold_chunk();
        logic [2*WORD_W-1:0] old_bytes;
        logic [2*WORD_W-1:0] new_bytes;
        logic [BYTE_W-1:0]   a;
        logic [BYTE_W-1:0]   b;
        logic [63:0]         acc;
        logic [63:0]         cost;
        int                  lanes;
        int                  i;
        t_row_cost           row;

        old_bytes = {i_chunk.old_pixels_high, i_chunk.old_pixels_low};
        new_bytes = {i_chunk.new_pixels_high, i_chunk.new_pixels_low};
        // counts above sixteen act as a full chunk
        lanes = (i_chunk.valid_bytes > LANES) ? LANES : int'(i_chunk.valid_bytes);
        acc   = '0;
        for (i = 0; i < lanes; i++) begin
            a = old_bytes[i*BYTE_W +: BYTE_W];
            b = new_bytes[i*BYTE_W +: BYTE_W];
            acc += (a > b) ? 64'(a - b) : 64'(b - a);
        end

        // the unused plane code adds nothing; sums stick at their ceiling
        if (i_chunk.plane < PLANES) begin
            acc += plane_sum[i_chunk.plane];
            plane_sum[i_chunk.plane] = (acc > SUM_MAX) ? SUM_MAX : acc[SUM_W-1:0];
        end

        // frame_end only counts together with row_end
        if (i_chunk.row_end) begin
            cost = '0;
            for (i = 0; i < PLANES; i++)
                cost += 64'(plane_sum[i]) * weight[i];
            acc         = 64'(frame_total) + cost;
            frame_total = (acc > TOTAL_MAX) ? TOTAL_MAX : acc[TOTAL_W-1:0];

            row.row_cost   = cost[COST_W-1:0];
            row.frame_cost = frame_total;
            row.last_row   = i_chunk.frame_end;
            expected_rows.push_back(row);

            for (i = 0; i < PLANES; i++)
                plane_sum[i] = '0;
            if (i_chunk.frame_end)
                frame_total = '0;
        end
    endtask

    task automatic check_result();
        t_row_cost want;

        if (expected_rows.size() == 0) begin
            report_mismatch("result beat with no row pending, row_cost",
                            i_result.row_cost, 64'(0));
        end else begin
            want = expected_rows.pop_front();
            if (i_result.row_cost !== want.row_cost)
                report_mismatch("row_cost", i_result.row_cost, want.row_cost);
            if (i_result.frame_cost !== want.frame_cost)
                report_mismatch("frame_cost", i_result.frame_cost, want.frame_cost);
            if (i_result.last_row !== want.last_row)
                report_mismatch("last_row", i_result.last_row, want.last_row);
        end
    endtask

    // Sample every beat at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (plane_sum[p]) plane_sum[p] = '0;
            foreach (weight[p]) weight[p] = WEIGHT_RESET;
            frame_total = '0;
            expected_rows.delete();
        end else begin
            if (i_result.valid && i_result.ready)
                check_result();
            // writes to the index past the last weight are dropped
            if (i_cfg_we && i_cfg_index < PLANES)
                weight[i_cfg_index] = i_cfg_data;
            if (i_chunk.valid && i_chunk.ready)
                fold_chunk();
        end
        rows_pending = expected_rows.size();
    end

endmodule

/* dv/tb_weighted_plane_row_sad.sv */
`timescale 1ns / 1ps

// ---------------------------------------------------------------------------
// tb_weighted_plane_row_sad
// Drives chunk beats and weight writes into the row SAD block: a directed
// opening over lane counts, plane codes and row and frame marks, random rows
// under several weight settings with stalls on both channels, and a final
// row whose plane sums all run into their ceiling. The checker beside the
// block predicts and compares every result beat.
// ---------------------------------------------------------------------------

module tb_weighted_plane_row_sad;
    import wprs_pkg::*;

    localparam int     CLK_HALF_NS   = 5;
    localparam int     RESET_CYCLES  = 9;
    localparam int     SETTLE_CYCLES = 10;     // pipe depth plus margin
    localparam longint TIMEOUT_NS    = 64'd25_000_000;
    localparam int     FULL_ROWS     = 1;      // rows with every plane sum saturated
    localparam int     FULL_CHUNKS   = 65;     // 65 x 4080 exceeds a plane sum's ceiling

    localparam logic [PLANE_W-1:0]   PLANE_NONE = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [COUNT_W-1:0]   FULL_COUNT = COUNT_W'(LANES);
    localparam logic [WORD_W-1:0]    ALL_ONES   = '1;
    localparam logic [WORD_W-1:0]    ALL_ZEROS  = '0;

    typedef struct packed {
        logic [WORD_W-1:0]  old_pixels_low;
        logic [WORD_W-1:0]  old_pixels_high;
        logic [WORD_W-1:0]  new_pixels_low;
        logic [WORD_W-1:0]  new_pixels_high;
        logic [PLANE_W-1:0] plane;
        logic [COUNT_W-1:0] valid_bytes;
        logic               row_end;
        logic               frame_end;
    } t_chunk_beat;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WEIGHT_W-1:0]  cfg_data;
    logic                 idling_on;
    int                   fail_count;
    int                   rows_pending;

    wprs_chunk_if  chunk_bus ();
    wprs_result_if result_bus ();

    weighted_plane_row_sad dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_chunk     (chunk_bus),
        .o_result    (result_bus),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    wprs_row_cost_checker row_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_chunk        (chunk_bus),
        .i_result       (result_bus),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_rows_pending (rows_pending)
    );

    always begin
        #CLK_HALF_NS clk = 1'b1;
        #CLK_HALF_NS clk = 1'b0;
    end

    function automatic t_chunk_beat chunk_of(
        input logic [WORD_W-1:0] old_lo, input logic [WORD_W-1:0] old_hi,
        input logic [WORD_W-1:0] new_lo, input logic [WORD_W-1:0] new_hi,
        input logic [PLANE_W-1:0] plane, input logic [COUNT_W-1:0] valid_bytes,
        input logic row_end, input logic frame_end);
        t_chunk_beat c;

        c.old_pixels_low  = old_lo;
        c.old_pixels_high = old_hi;
        c.new_pixels_low  = new_lo;
        c.new_pixels_high = new_hi;
        c.plane           = plane;
        c.valid_bytes     = valid_bytes;
        c.row_end         = row_end;
        c.frame_end       = frame_end;
        return c;
    endfunction

    // Random pixels, with extreme and equal chunks mixed in
    function automatic t_chunk_beat random_chunk(input logic [PLANE_W-1:0] plane,
                                                 input logic row_end,
                                                 input logic frame_end);
        t_chunk_beat c;
        int          pick;

        c = chunk_of({$urandom, $urandom}, {$urandom, $urandom},
                     {$urandom, $urandom}, {$urandom, $urandom},
                     plane, FULL_COUNT, row_end, frame_end);
        pick = $urandom_range(0, 9);
        unique case (pick)
            0: begin
                c.old_pixels_low  = ALL_ZEROS;
                c.old_pixels_high = ALL_ZEROS;
                c.new_pixels_low  = ALL_ONES;
                c.new_pixels_high = ALL_ONES;
            end
            1: begin
                c.old_pixels_low  = ALL_ONES;
                c.old_pixels_high = ALL_ONES;
                c.new_pixels_low  = ALL_ZEROS;
                c.new_pixels_high = ALL_ZEROS;
            end
            2: begin
                c.new_pixels_low  = c.old_pixels_low;
                c.new_pixels_high = c.old_pixels_high;
            end
            default: ;
        endcase
        // mostly full chunks, some partial, a few zero or oversized counts
        pick = $urandom_range(0, 19);
        if (pick >= 19)
            c.valid_bytes = COUNT_W'($urandom_range(0, 2**COUNT_W - 1));
        else if (pick >= 13)
            c.valid_bytes = COUNT_W'($urandom_range(1, LANES - 1));
        return c;
    endfunction

    // Present one beat at the falling edge and hold it until accepted
    task automatic send_chunk(input t_chunk_beat c);
        chunk_bus.valid           <= 1'b1;
        chunk_bus.old_pixels_low  <= c.old_pixels_low;
        chunk_bus.old_pixels_high <= c.old_pixels_high;
        chunk_bus.new_pixels_low  <= c.new_pixels_low;
        chunk_bus.new_pixels_high <= c.new_pixels_high;
        chunk_bus.plane           <= c.plane;
        chunk_bus.valid_bytes     <= c.valid_bytes;
        chunk_bus.row_end         <= c.row_end;
        chunk_bus.frame_end       <= c.frame_end;
        @(posedge clk);
        while (!chunk_bus.ready) @(posedge clk);
        @(negedge clk);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            chunk_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
    endtask

    // Wait for every pending row, then for the pipe to empty
    task automatic drain();
        chunk_bus.valid <= 1'b0;
        while (rows_pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Back-to-back writes of all three weights, then one to the unused index
    task automatic set_weights(input logic [WEIGHT_W-1:0] w_luma,
                               input logic [WEIGHT_W-1:0] w_cb,
                               input logic [WEIGHT_W-1:0] w_cr,
                               input logic [WEIGHT_W-1:0] stray);
        cfg_we    <= 1'b1;
        cfg_index <= REG_WEIGHT_LUMA;
        cfg_data  <= w_luma;
        @(negedge clk);
        cfg_index <= REG_WEIGHT_CB;
        cfg_data  <= w_cb;
        @(negedge clk);
        cfg_index <= REG_WEIGHT_CR;
        cfg_data  <= w_cr;
        @(negedge clk);
        cfg_index <= REG_UNUSED;
        cfg_data  <= stray;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    // Mostly whole rows (luma, Cb, Cr runs, row end on the last Cr chunk),
    // the rest loose chunks with any plane code and any marks
    task automatic send_random(input int n_chunks);
        int   sent;
        int   p;
        int   k;
        int   per_plane;
        logic closes_frame;
        logic last;

        sent = 0;
        while (sent < n_chunks) begin
            if ($urandom_range(0, 9) < 8) begin
                closes_frame = ($urandom_range(0, 3) == 0);
                for (p = 0; p < PLANES; p++) begin
                    per_plane = $urandom_range(1, 3);
                    for (k = 0; k < per_plane; k++) begin
                        last = (p == PLANES - 1) && (k == per_plane - 1);
                        send_chunk(random_chunk(PLANE_W'(p), last, last && closes_frame));
                        sent++;
                    end
                end
            end else begin
                send_chunk(random_chunk(PLANE_W'($urandom_range(0, 3)),
                                        1'($urandom_range(0, 1)),
                                        1'($urandom_range(0, 1))));
                sent++;
            end
        end
    endtask

    // Result side: random stall bursts while idling is on
    initial begin : result_sink
        int hold;

        hold = 0;
        result_bus.ready <= 1'b1;
        forever begin
            @(negedge clk);
            if (!idling_on)
                hold = 0;
            else if (hold > 0)
                hold--;
            else if ($urandom_range(0, 5) == 0)
                hold = $urandom_range(1, 6);
            result_bus.ready <= (hold == 0);
        end
    end

    initial begin : stimulus
        int   row;
        int   p;
        int   k;
        logic last;

        rst_n                     <= 1'b0;
        cfg_we                    <= 1'b0;
        cfg_index                 <= REG_WEIGHT_LUMA;
        cfg_data                  <= '0;
        idling_on                 <= 1'b0;
        chunk_bus.valid           <= 1'b0;
        chunk_bus.old_pixels_low  <= '0;
        chunk_bus.old_pixels_high <= '0;
        chunk_bus.new_pixels_low  <= '0;
        chunk_bus.new_pixels_high <= '0;
        chunk_bus.plane           <= PLANE_LUMA;
        chunk_bus.valid_bytes     <= '0;
        chunk_bus.row_end         <= 1'b0;
        chunk_bus.frame_end       <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n     <= 1'b1;
        idling_on <= 1'b1;

        // Directed part under reset weights
        // full-swing chunks in both directions
        send_chunk(chunk_of(ALL_ZEROS, ALL_ZEROS, ALL_ONES, ALL_ONES,
                            PLANE_LUMA, FULL_COUNT, 1'b0, 1'b0));
        send_chunk(chunk_of(ALL_ONES, ALL_ONES, ALL_ZEROS, ALL_ZEROS,
                            PLANE_CB, FULL_COUNT, 1'b0, 1'b0));
        // one lane per count bit
        send_chunk(chunk_of({$urandom, $urandom}, {$urandom, $urandom},
                            {$urandom, $urandom}, {$urandom, $urandom},
                            PLANE_CR, 5'd1, 1'b0, 1'b0));
        send_chunk(chunk_of({$urandom, $urandom}, {$urandom, $urandom},
                            {$urandom, $urandom}, {$urandom, $urandom},
                            PLANE_LUMA, 5'd2, 1'b0, 1'b0));
        send_chunk(chunk_of({$urandom, $urandom}, {$urandom, $urandom},
                            {$urandom, $urandom}, {$urandom, $urandom},
                            PLANE_CB, 5'd4, 1'b0, 1'b0));
        send_chunk(chunk_of({$urandom, $urandom}, {$urandom, $urandom},
                            {$urandom, $urandom}, {$urandom, $urandom},
                            PLANE_CR, 5'd8, 1'b0, 1'b0));
        // unused plane code adds nothing
        send_chunk(chunk_of(ALL_ZEROS, ALL_ZEROS, ALL_ONES, ALL_ONES,
                            PLANE_NONE, FULL_COUNT, 1'b0, 1'b0));
        // zero lanes, then counts past sixteen
        send_chunk(chunk_of(ALL_ZEROS, ALL_ZEROS, ALL_ONES, ALL_ONES,
                            PLANE_LUMA, 5'd0, 1'b0, 1'b0));
        send_chunk(chunk_of(ALL_ZEROS, ALL_ZEROS, ALL_ONES, ALL_ONES,
                            PLANE_CB, 5'd31, 1'b0, 1'b0));
        send_chunk(chunk_of(ALL_ZEROS, ALL_ZEROS, ALL_ONES, ALL_ONES,
                            PLANE_CR, 5'd17, 1'b0, 1'b0));
        // frame end with no row end is ignored
        send_chunk(chunk_of({$urandom, $urandom}, {$urandom, $urandom},
                            {$urandom, $urandom}, {$urandom, $urandom},
                            PLANE_LUMA, FULL_COUNT, 1'b0, 1'b1));
        send_chunk(chunk_of({$urandom, $urandom}, {$urandom, $urandom},
                            {$urandom, $urandom}, {$urandom, $urandom},
                            PLANE_CR, 5'd15, 1'b1, 1'b0));
        // row and frame end on the unused plane code
        send_chunk(chunk_of(ALL_ZEROS, ALL_ZEROS, ALL_ONES, ALL_ONES,
                            PLANE_NONE, FULL_COUNT, 1'b1, 1'b1));
        // empty row right after a frame end, equal pixels
        send_chunk(chunk_of(ALL_ONES, ALL_ZEROS, ALL_ONES, ALL_ZEROS,
                            PLANE_LUMA, FULL_COUNT, 1'b1, 1'b0));
        send_chunk(chunk_of({$urandom, $urandom}, {$urandom, $urandom},
                            {$urandom, $urandom}, {$urandom, $urandom},
                            PLANE_LUMA, FULL_COUNT, 1'b1, 1'b1));
        // alternating bit patterns, then a chunk whose ninth lane alone differs
        send_chunk(chunk_of({8{8'hAA}}, {8{8'h55}}, {8{8'h55}}, {8{8'hAA}},
                            PLANE_CB, FULL_COUNT, 1'b0, 1'b0));
        send_chunk(chunk_of(ALL_ZEROS, ALL_ONES, ALL_ZEROS, ALL_ZEROS,
                            PLANE_LUMA, 5'd9, 1'b0, 1'b0));
        send_chunk(chunk_of({$urandom, $urandom}, {$urandom, $urandom},
                            {$urandom, $urandom}, {$urandom, $urandom},
                            PLANE_CR, FULL_COUNT, 1'b1, 1'b0));
        send_chunk(chunk_of(ALL_ONES, ALL_ONES, ALL_ZEROS, ALL_ZEROS,
                            PLANE_CB, FULL_COUNT, 1'b1, 1'b1));

        // Random rows under several weight settings; each drain holds the
        // sender until every row result is back
        drain();
        set_weights(8'd255, 8'd0, 8'd255, 8'hA5);
        send_random(150);
        drain();
        set_weights(8'd0, 8'd0, 8'd0, 8'hFF);
        send_random(100);
        drain();
        set_weights(WEIGHT_W'($urandom_range(0, 255)), WEIGHT_W'($urandom_range(0, 255)),
                    WEIGHT_W'($urandom_range(0, 255)), WEIGHT_W'($urandom_range(0, 255)));
        send_random(200);
        drain();
        set_weights(8'd255, 8'd255, 8'd255, 8'h00);
        send_random(180);
        drain();

        // Last part, no stalls: a row with every plane sum saturated gives
        // the largest row cost; the final row closes the frame
        idling_on <= 1'b0;
        for (row = 0; row < FULL_ROWS; row++) begin
            for (p = 0; p < PLANES; p++) begin
                for (k = 0; k < FULL_CHUNKS; k++) begin
                    last = (p == PLANES - 1) && (k == FULL_CHUNKS - 1);
                    send_chunk(chunk_of(ALL_ZEROS, ALL_ZEROS, ALL_ONES, ALL_ONES,
                                        PLANE_W'(p), FULL_COUNT, last,
                                        last && (row == FULL_ROWS - 1)));
                end
            end
        end
        drain();

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
